### hdl/ifu_pkg.sv
package ifu_pkg;

  typedef enum logic [1:0] {
    LEN_FIX = 2'd0,
    LEN_V2  = 2'd1,
    LEN_V4  = 2'd2
  } len_mode_e;

  typedef enum logic [1:0] {
    KIND_BCD_R = 2'd0,
    KIND_BCD_L = 2'd1,
    KIND_BIN   = 2'd2,
    KIND_ASC   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PART_PREFIX  = 2'd0,
    PART_CONTENT = 2'd1,
    PART_PAD     = 2'd2,
    PART_STRAY   = 2'd3
  } part_e;

  localparam int unsigned FieldW = 7;
  localparam int unsigned CountW = 15;
  localparam int unsigned LenW   = 14;
  localparam int unsigned MaxW   = 10;
  localparam int unsigned LastField = 64;

  typedef struct packed {
    len_mode_e         mode;
    kind_e             kind;
    logic [MaxW-1:0]   max_len;
  } rule_t;

  typedef struct packed {
    logic [FieldW-1:0] field_number;
    logic [3:0]        nibble;
    part_e             part;
    kind_e             content_kind;
    logic              field_end;
    logic              message_end;
    logic              over_limit;
  } ifu_result_t;

  function automatic rule_t ifu_rule(input logic [FieldW-1:0] f);
    rule_t r;
    r = '{LEN_FIX, KIND_BCD_R, 10'd0};
    case (f)
      7'd0:    r = '{LEN_FIX, KIND_BCD_R, 10'd4};
      7'd1:    r = '{LEN_FIX, KIND_BCD_R, 10'd16};
      7'd2:    r = '{LEN_V2,  KIND_BCD_L, 10'd19};
      7'd3:    r = '{LEN_FIX, KIND_BCD_R, 10'd6};
      7'd4:    r = '{LEN_FIX, KIND_BCD_R, 10'd12};
      7'd11:   r = '{LEN_FIX, KIND_BCD_R, 10'd6};
      7'd12:   r = '{LEN_FIX, KIND_BCD_R, 10'd6};
      7'd13:   r = '{LEN_FIX, KIND_BCD_R, 10'd4};
      7'd14:   r = '{LEN_FIX, KIND_BCD_R, 10'd4};
      7'd15:   r = '{LEN_FIX, KIND_BCD_R, 10'd4};
      7'd22:   r = '{LEN_FIX, KIND_BCD_L, 10'd3};
      7'd23:   r = '{LEN_FIX, KIND_BCD_R, 10'd4};
      7'd25:   r = '{LEN_FIX, KIND_BCD_R, 10'd2};
      7'd26:   r = '{LEN_FIX, KIND_BCD_R, 10'd2};
      7'd32:   r = '{LEN_V2,  KIND_BCD_R, 10'd11};
      7'd35:   r = '{LEN_V2,  KIND_BCD_L, 10'd37};
      7'd36:   r = '{LEN_V4,  KIND_BCD_L, 10'd104};
      7'd37:   r = '{LEN_FIX, KIND_BIN,   10'd12};
      7'd38:   r = '{LEN_FIX, KIND_BIN,   10'd6};
      7'd39:   r = '{LEN_FIX, KIND_BIN,   10'd2};
      7'd41:   r = '{LEN_FIX, KIND_BIN,   10'd8};
      7'd42:   r = '{LEN_FIX, KIND_BIN,   10'd15};
      7'd44:   r = '{LEN_V2,  KIND_BIN,   10'd25};
      7'd45:   r = '{LEN_V2,  KIND_BIN,   10'd38};
      7'd48:   r = '{LEN_V4,  KIND_BCD_L, 10'd322};
      7'd49:   r = '{LEN_FIX, KIND_BIN,   10'd3};
      7'd52:   r = '{LEN_FIX, KIND_ASC,   10'd8};
      7'd53:   r = '{LEN_FIX, KIND_BCD_R, 10'd16};
      7'd54:   r = '{LEN_V4,  KIND_BIN,   10'd20};
      7'd55:   r = '{LEN_V4,  KIND_ASC,   10'd255};
      7'd56:   r = '{LEN_V4,  KIND_ASC,   10'd999};
      7'd57:   r = '{LEN_V4,  KIND_ASC,   10'd999};
      7'd58:   r = '{LEN_V4,  KIND_BIN,   10'd100};
      7'd60:   r = '{LEN_V4,  KIND_BCD_L, 10'd17};
      7'd61:   r = '{LEN_V4,  KIND_BCD_L, 10'd29};
      7'd62:   r = '{LEN_V4,  KIND_ASC,   10'd512};
      7'd63:   r = '{LEN_V4,  KIND_BIN,   10'd163};
      7'd64:   r = '{LEN_FIX, KIND_BCD_R, 10'd8};
      default: r = '{LEN_FIX, KIND_BCD_R, 10'd0};
    endcase
    return r;
  endfunction

  // Bit k-1 set when field k occupies at least one nibble.
  function automatic logic [LastField-1:0] ifu_nonempty_mask();
    logic [LastField-1:0] m;
    rule_t r;
    m = '0;
    for (int k = 1; k <= LastField; k++) begin
      r = ifu_rule(FieldW'(k));
      m[k-1] = (r.mode != LEN_FIX) || (r.max_len != '0);
    end
    return m;
  endfunction

  function automatic logic [CountW-1:0] ifu_content_nibbles(input logic [LenW-1:0] len,
                                                             input kind_e kind);
    logic [CountW-1:0] n;
    case (kind)
      KIND_BCD_R: n = {1'b0, len};
      KIND_BCD_L: n = {1'b0, len} + {{(CountW-1){1'b0}}, len[0]};
      default:    n = {len, 1'b0};
    endcase
    return n;
  endfunction

endpackage

### hdl/ifu_in_if.sv
interface ifu_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic       first;

  modport source (output valid, output digit, output first, input ready);
  modport sink (input valid, input digit, input first, output ready);
endinterface

### hdl/ifu_out_if.sv
interface ifu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] field_number;
  logic [3:0] nibble;
  logic [1:0] part;
  logic [1:0] content_kind;
  logic       field_end;
  logic       message_end;
  logic       over_limit;

  modport source (output valid, output field_number, output nibble, output part,
                  output content_kind, output field_end, output message_end,
                  output over_limit, input ready);
  modport sink (input valid, input field_number, input nibble, input part,
                input content_kind, input field_end, input message_end,
                input over_limit, output ready);
endinterface

### hdl/ifu_front.sv
module ifu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [3:0]           digit_i,
  input  logic                 first_i,
  output ifu_pkg::ifu_result_t result_o
);
  import ifu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MTYPE, PH_BITMAP, PH_PREFIX, PH_CONTENT, PH_DONE
  } phase_e;

  localparam logic [LastField-1:0] NonemptyMask = ifu_nonempty_mask();

  phase_e               phase_q, phase_d;
  logic [FieldW-1:0]    field_q, field_d;
  logic [LastField-1:0] map_q, map_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [LenW-1:0]      len_q, len_d;
  logic                 stop_q, stop_d;

  logic [FieldW-1:0]    safe_field;
  rule_t                cur_rule;
  rule_t                next_rule;
  logic [CountW-1:0]    total;
  logic [CountW-1:0]    need;
  logic [3:0]           rev_digit;
  logic                 do_adv;
  logic [LastField-1:0] cand;
  logic [FieldW-1:0]    next_field;
  ifu_result_t          res;

  assign rev_digit = {digit_i[0], digit_i[1], digit_i[2], digit_i[3]};

  always_comb begin
    phase_d = first_i ? PH_MTYPE : phase_q;
    field_d = first_i ? '0 : field_q;
    map_d   = first_i ? '0 : map_q;
    count_d = first_i ? '0 : count_q;
    len_d   = first_i ? '0 : len_q;
    stop_d  = first_i ? 1'b0 : stop_q;

    res              = '0;
    res.nibble       = digit_i;
    res.part         = PART_STRAY;
    res.content_kind = KIND_BCD_R;
    do_adv           = 1'b0;

    safe_field = (field_d > FieldW'(LastField)) ? '0 : field_d;
    cur_rule   = ifu_rule(safe_field);
    need       = (cur_rule.mode == LEN_V2) ? CountW'(2) : CountW'(4);
    total      = '0;

    case (phase_d)
      PH_MTYPE: begin
        res.part = PART_CONTENT;
        count_d  = count_d + 1'b1;
        if (count_d >= CountW'(4)) begin
          res.field_end = 1'b1;
          phase_d       = PH_BITMAP;
          count_d       = '0;
        end
      end
      PH_BITMAP: begin
        res.field_number = FieldW'(1);
        res.part         = PART_CONTENT;
        map_d   = map_d | ({{(LastField-4){1'b0}}, rev_digit} << {count_d[3:0], 2'b00});
        count_d = count_d + 1'b1;
        if (count_d >= CountW'(16)) begin
          res.field_end = 1'b1;
          field_d       = FieldW'(1);
          do_adv        = 1'b1;
        end
      end
      PH_PREFIX: begin
        res.field_number = safe_field;
        res.part         = PART_PREFIX;
        res.content_kind = cur_rule.kind;
        if (!stop_d && digit_i < 4'd10) begin
          len_d = (len_d << 3) + (len_d << 1) + LenW'(digit_i);
        end else begin
          stop_d = 1'b1;
        end
        count_d = count_d + 1'b1;
        if (count_d >= need) begin
          total          = ifu_content_nibbles(len_d, cur_rule.kind);
          res.over_limit = len_d > LenW'(cur_rule.max_len);
          if (total == '0) begin
            res.field_end = 1'b1;
            do_adv        = 1'b1;
          end else begin
            count_d = total;
            phase_d = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        res.field_number = safe_field;
        res.content_kind = cur_rule.kind;
        res.part = (cur_rule.kind == KIND_BCD_L && len_d[0] && count_d == CountW'(1))
                   ? PART_PAD : PART_CONTENT;
        res.over_limit = (cur_rule.mode != LEN_FIX) && (len_d > LenW'(cur_rule.max_len));
        if (count_d != '0) count_d = count_d - 1'b1;
        if (count_d == '0) begin
          res.field_end = 1'b1;
          do_adv        = 1'b1;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Lowest present, nonempty field above the current one.
    cand = map_d & NonemptyMask &
           ~((LastField'(1) << (field_d > FieldW'(LastField) ? '0 : field_d)) - LastField'(1));
    next_field = '0;
    for (int i = LastField - 1; i >= 0; i--) begin
      if (cand[i]) next_field = FieldW'(i + 1);
    end
    next_rule = ifu_rule(next_field);

    if (do_adv) begin
      if (next_field == '0) begin
        phase_d         = PH_DONE;
        res.message_end = 1'b1;
      end else begin
        field_d = next_field;
        stop_d  = 1'b0;
        if (next_rule.mode == LEN_FIX) begin
          len_d   = LenW'(next_rule.max_len);
          count_d = ifu_content_nibbles(LenW'(next_rule.max_len), next_rule.kind);
          phase_d = PH_CONTENT;
        end else begin
          len_d   = '0;
          count_d = '0;
          phase_d = PH_PREFIX;
        end
      end
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      field_q <= '0;
      map_q   <= '0;
      count_q <= '0;
      len_q   <= '0;
      stop_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      field_q <= field_d;
      map_q   <= map_d;
      count_q <= count_d;
      len_q   <= len_d;
      stop_q  <= stop_d;
    end
  end

endmodule

### hdl/ifu_queue.sv
module ifu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ifu_pkg::ifu_result_t push_data_i,
  output logic                 full_o,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output ifu_pkg::ifu_result_t pop_data_o
);
  import ifu_pkg::*;

  ifu_result_t mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  count_q;
  logic        pop;

  assign full_o      = count_q == 2'd2;
  assign pop_valid_o = count_q != 2'd0;
  assign pop_data_o  = mem_q[rd_q];
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/iso8583_field_unpacker.sv
// Output: a nibble accepted at a clock edge is written into the queue and shows on the output
//   channel right after that edge when the output side is idle.
// Throughput: one nibble per cycle while the queue has room; the parse loop (next-field
//   search, decimal accumulate) is combinational; a 2-entry queue absorbs output stalls.
// Reset: asynchronous, active low; clears the parse to waiting for a first nibble and
//   empties the queue.
module iso8583_field_unpacker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifu_in_if.sink     in_i,
  ifu_out_if.source  out_o
);
  import ifu_pkg::*;

  logic        full;
  logic        accept;
  ifu_result_t front_res;
  ifu_result_t head;

  // Take a nibble whenever the queue has room; ready does not look at the output's ready.
  assign in_i.ready = ~full;
  assign accept     = in_i.valid & in_i.ready;

  // Front: classify each nibble against the running parse state.
  ifu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .digit_i  (in_i.digit),
    .first_i  (in_i.first),
    .result_o (front_res)
  );

  // Back: hold tagged items until the consumer takes them.
  ifu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_res),
    .full_o      (full),
    .pop_valid_o (out_o.valid),
    .pop_ready_i (out_o.ready),
    .pop_data_o  (head)
  );

  // Unpack the head item onto the output channel.
  assign out_o.field_number = head.field_number;
  assign out_o.nibble       = head.nibble;
  assign out_o.part         = head.part;
  assign out_o.content_kind = head.content_kind;
  assign out_o.field_end    = head.field_end;
  assign out_o.message_end  = head.message_end;
  assign out_o.over_limit   = head.over_limit;

endmodule

### tb/iso8583_field_unpacker_test.sv
`timescale 1ns / 100ps

module iso8583_field_unpacker_test;
  import ifu_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The long
  // receiver hold lasts HoldCycles, so this leaves ample margin.
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldStart  = 800;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomNibbles = 880;
  localparam int unsigned ReportLimit = 10;

  // Parse phases of the local predictor.
  typedef enum logic [2:0] {
    P_WAIT,
    P_TYPE,
    P_MAP,
    P_LEN,
    P_BODY,
    P_DONE
  } parse_phase_e;

  typedef struct {
    len_mode_e   mode;
    kind_e       kind;
    int unsigned limit_len;
  } unpack_rule_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       starts;
  } nib_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ifu_in_if  in_bus ();
  ifu_out_if out_bus ();

  iso8583_field_unpacker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Nibbles waiting to be sent, and tagged nibbles waiting to come back.
  nib_item_t   nibble_feed[$];
  ifu_result_t tagged_nibbles[$];
  logic [3:0]  prefix_script[$];

  int unsigned errors     = 0;
  int unsigned idle_count = 0;

  // Predictor state: mirrors the parse registers of the block.
  parse_phase_e      parse_phase = P_WAIT;
  logic [FieldW-1:0] cur_field   = '0;
  logic [63:0]       field_map   = '0;
  logic [CountW-1:0] nib_left    = '0;
  logic [LenW-1:0]   decl_len    = '0;
  logic              len_halted  = 1'b0;

  // Field layout rules, grouped by how the field is framed.
  function automatic unpack_rule_t unpack_rule(input int unsigned k);
    unpack_rule_t rl;
    case (k)
      0, 13, 14, 15, 23: rl = '{LEN_FIX, KIND_BCD_R, 4};
      1, 53:             rl = '{LEN_FIX, KIND_BCD_R, 16};
      3, 11, 12:         rl = '{LEN_FIX, KIND_BCD_R, 6};
      4:                 rl = '{LEN_FIX, KIND_BCD_R, 12};
      25, 26:            rl = '{LEN_FIX, KIND_BCD_R, 2};
      64:                rl = '{LEN_FIX, KIND_BCD_R, 8};
      22:                rl = '{LEN_FIX, KIND_BCD_L, 3};
      37:                rl = '{LEN_FIX, KIND_BIN, 12};
      38:                rl = '{LEN_FIX, KIND_BIN, 6};
      39:                rl = '{LEN_FIX, KIND_BIN, 2};
      41:                rl = '{LEN_FIX, KIND_BIN, 8};
      42:                rl = '{LEN_FIX, KIND_BIN, 15};
      49:                rl = '{LEN_FIX, KIND_BIN, 3};
      52:                rl = '{LEN_FIX, KIND_ASC, 8};
      2:                 rl = '{LEN_V2, KIND_BCD_L, 19};
      35:                rl = '{LEN_V2, KIND_BCD_L, 37};
      32:                rl = '{LEN_V2, KIND_BCD_R, 11};
      44:                rl = '{LEN_V2, KIND_BIN, 25};
      45:                rl = '{LEN_V2, KIND_BIN, 38};
      36:                rl = '{LEN_V4, KIND_BCD_L, 104};
      48:                rl = '{LEN_V4, KIND_BCD_L, 322};
      60:                rl = '{LEN_V4, KIND_BCD_L, 17};
      61:                rl = '{LEN_V4, KIND_BCD_L, 29};
      54:                rl = '{LEN_V4, KIND_BIN, 20};
      58:                rl = '{LEN_V4, KIND_BIN, 100};
      63:                rl = '{LEN_V4, KIND_BIN, 163};
      55:                rl = '{LEN_V4, KIND_ASC, 255};
      56, 57:            rl = '{LEN_V4, KIND_ASC, 999};
      62:                rl = '{LEN_V4, KIND_ASC, 512};
      default:           rl = '{LEN_FIX, KIND_BCD_R, 0};
    endcase
    return rl;
  endfunction

  // Nibbles of content for a declared length: left BCD pads odd lengths,
  // binary and ASCII take two nibbles per unit.
  function automatic int unsigned body_nibbles(input int unsigned len, input kind_e kind);
    case (kind)
      KIND_BCD_R: return len;
      KIND_BCD_L: return len + (len & 1);
      default:    return 2 * len;
    endcase
  endfunction

  // Step to the next present field that occupies nibbles; return 1 when none is left.
  function automatic logic move_to_next_field();
    unpack_rule_t rl;
    for (int unsigned k = cur_field + 1; k <= LastField; k++) begin
      rl = unpack_rule(k);
      if (field_map[k-1] && (rl.mode != LEN_FIX || rl.limit_len != 0)) begin
        cur_field  = FieldW'(k);
        len_halted = 1'b0;
        if (rl.mode == LEN_FIX) begin
          decl_len    = LenW'(rl.limit_len);
          nib_left    = CountW'(body_nibbles(rl.limit_len, rl.kind));
          parse_phase = P_BODY;
        end else begin
          decl_len    = '0;
          nib_left    = '0;
          parse_phase = P_LEN;
        end
        return 1'b0;
      end
    end
    parse_phase = P_DONE;
    return 1'b1;
  endfunction

  // Work out the tag of one accepted nibble and advance the parse.
  function automatic ifu_result_t parse_nibble(input logic [3:0] d, input logic starts);
    ifu_result_t  r;
    unpack_rule_t rl;
    int unsigned  need;
    int unsigned  total;
    r              = '0;
    r.nibble       = d;
    r.part         = PART_STRAY;
    r.content_kind = KIND_BCD_R;
    if (starts) begin
      parse_phase = P_TYPE;
      cur_field   = '0;
      field_map   = '0;
      nib_left    = '0;
      decl_len    = '0;
      len_halted  = 1'b0;
    end
    case (parse_phase)
      P_TYPE: begin
        r.part   = PART_CONTENT;
        nib_left = nib_left + 1'b1;
        if (nib_left >= 4) begin
          r.field_end = 1'b1;
          parse_phase = P_MAP;
          nib_left    = '0;
        end
      end
      P_MAP: begin
        r.field_number = FieldW'(1);
        r.part         = PART_CONTENT;
        for (int b = 0; b < 4; b++) begin
          if (d[3-b]) field_map[nib_left[3:0]*4 + b] = 1'b1;
        end
        nib_left = nib_left + 1'b1;
        if (nib_left >= 16) begin
          r.field_end   = 1'b1;
          cur_field     = FieldW'(1);
          r.message_end = move_to_next_field();
        end
      end
      P_LEN: begin
        rl             = unpack_rule(cur_field);
        need           = (rl.mode == LEN_V2) ? 2 : 4;
        r.field_number = cur_field;
        r.part         = PART_PREFIX;
        r.content_kind = rl.kind;
        // Accumulate decimal digits; the first non-decimal digit freezes the value.
        if (!len_halted && d < 4'd10) decl_len = LenW'(decl_len * 10 + d);
        else len_halted = 1'b1;
        nib_left = nib_left + 1'b1;
        if (nib_left >= need) begin
          total        = body_nibbles(decl_len, rl.kind);
          r.over_limit = (decl_len > rl.limit_len);
          if (total == 0) begin
            r.field_end   = 1'b1;
            r.message_end = move_to_next_field();
          end else begin
            nib_left    = CountW'(total);
            parse_phase = P_BODY;
          end
        end
      end
      P_BODY: begin
        rl             = unpack_rule(cur_field);
        r.field_number = cur_field;
        r.content_kind = rl.kind;
        r.part         = (rl.kind == KIND_BCD_L && decl_len[0] && nib_left == 1) ?
                         PART_PAD : PART_CONTENT;
        r.over_limit   = (rl.mode != LEN_FIX) && (decl_len > rl.limit_len);
        if (nib_left > 0) nib_left = nib_left - 1'b1;
        if (nib_left == 0) begin
          r.field_end   = 1'b1;
          r.message_end = move_to_next_field();
        end
      end
      default: begin
        // Stray nibble: before any message start or after the message ended.
      end
    endcase
    return r;
  endfunction

  // Queue one message: type, bitmap, then every present field with a length prefix
  // where the field is variable. Prefix digits come from prefix_script when it holds
  // enough of them, else they are drawn at random with lengths mostly up to cap.
  // A non-negative cut_at truncates the message so that the next start abandons it.
  task automatic build_message(input logic [63:0] fmap, input int unsigned cap,
                               input int cut_at);
    nib_item_t    msg[$];
    unpack_rule_t rl;
    int unsigned  need;
    int unsigned  len;
    int unsigned  base;
    int unsigned  pick;
    int unsigned  v;
    int unsigned  stop_at;
    logic [3:0]   pre[4];
    logic         halted;
    msg.push_back('{4'($urandom_range(0, 15)), 1'b1});
    repeat (3) msg.push_back('{4'($urandom_range(0, 15)), 1'b0});
    for (int i = 0; i < 16; i++) begin
      msg.push_back('{{fmap[4*i], fmap[4*i+1], fmap[4*i+2], fmap[4*i+3]}, 1'b0});
    end
    for (int unsigned k = 2; k <= LastField; k++) begin
      rl = unpack_rule(k);
      if (!fmap[k-1] || (rl.mode == LEN_FIX && rl.limit_len == 0)) continue;
      if (rl.mode == LEN_FIX) begin
        len = rl.limit_len;
      end else begin
        need = (rl.mode == LEN_V2) ? 2 : 4;
        if (prefix_script.size() >= need) begin
          for (int i = 0; i < need; i++) pre[i] = prefix_script.pop_front();
        end else begin
          base = (rl.limit_len < cap) ? rl.limit_len : cap;
          pick = $urandom_range(0, 9);
          if (pick == 0) len = 0;
          else if (pick <= 6) len = $urandom_range(1, base);
          else if (pick == 8 && rl.limit_len < 64) len = rl.limit_len + $urandom_range(1, 3);
          else if (pick == 9) len = $urandom_range(0, base);
          else len = base;
          v = len;
          for (int i = need - 1; i >= 0; i--) begin
            pre[i] = 4'(v % 10);
            v      = v / 10;
          end
          // Break the prefix with a non-decimal digit and noise after it.
          if (pick == 9) begin
            stop_at      = $urandom_range(0, need - 1);
            pre[stop_at] = 4'($urandom_range(10, 15));
            for (int i = stop_at + 1; i < need; i++) pre[i] = 4'($urandom_range(0, 15));
          end
        end
        len    = 0;
        halted = 1'b0;
        for (int i = 0; i < need; i++) begin
          msg.push_back('{pre[i], 1'b0});
          if (!halted && pre[i] < 4'd10) len = len * 10 + pre[i];
          else halted = 1'b1;
        end
      end
      repeat (body_nibbles(len, rl.kind)) msg.push_back('{4'($urandom_range(0, 15)), 1'b0});
    end
    if (cut_at >= 0) begin
      while (msg.size() > cut_at) void'(msg.pop_back());
    end
    foreach (msg[i]) nibble_feed.push_back(msg[i]);
  endtask

  task automatic add_strays(input int unsigned n);
    repeat (n) nibble_feed.push_back('{4'($urandom_range(0, 15)), 1'b0});
  endtask

  // Sparse random bitmap; density varies from message to message.
  function automatic logic [63:0] random_map();
    logic [63:0] m;
    int unsigned spread;
    spread = $urandom_range(0, 2);
    for (int i = 0; i < 64; i++) begin
      m[i] = ($urandom_range(0, (spread == 0) ? 15 : (spread == 1) ? 5 : 2) == 0);
    end
    return m;
  endfunction

  // Sender: bursts of random length with random gaps; hold an offered nibble
  // until it is taken, and predict its tag the moment it is accepted.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    nib_item_t nx;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.digit <= '0;
      in_bus.first <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        tagged_nibbles.push_back(parse_nibble(in_bus.digit, in_bus.first));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (nibble_feed.size() > 0) begin
          nx = nibble_feed.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.digit <= nx.digit;
          in_bus.first <= nx.starts;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; some run long with no gap at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                                                       $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in one of four styles, picked anew at random, and once hold off for a long
  // stretch so that the block's output queue fills and it stalls its input.
  int unsigned rx_cycles   = 0;
  int unsigned stall_style = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 50 == 0) stall_style = $urandom_range(0, 3);
      if (rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldCycles) begin
        out_bus.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ((rx_cycles / 3) % 2 == 0);
        endcase
      end
    end
  end

  // Check each accepted result against the oldest expected tag.
  always @(posedge clk_i) begin
    ifu_result_t want;
    ifu_result_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.field_number, out_bus.nibble, part_e'(out_bus.part),
              kind_e'(out_bus.content_kind), out_bus.field_end, out_bus.message_end,
              out_bus.over_limit};
      if (tagged_nibbles.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("unexpected result: fn=%0d nib=%h part=%0d kind=%0d fe=%b me=%b ol=%b",
                   got.field_number, got.nibble, got.part, got.content_kind,
                   got.field_end, got.message_end, got.over_limit);
        end
      end else begin
        want = tagged_nibbles.pop_front();
        if (got.field_number != want.field_number || got.nibble != want.nibble ||
            got.part != want.part || got.content_kind != want.content_kind ||
            got.field_end != want.field_end || got.message_end != want.message_end ||
            got.over_limit != want.over_limit) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("mismatch want: fn=%0d nib=%h part=%0d kind=%0d fe=%b me=%b ol=%b",
                     want.field_number, want.nibble, want.part, want.content_kind,
                     want.field_end, want.message_end, want.over_limit);
            $display("          got: fn=%0d nib=%h part=%0d kind=%0d fe=%b me=%b ol=%b",
                     got.field_number, got.nibble, got.part, got.content_kind,
                     got.field_end, got.message_end, got.over_limit);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count == IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] fmap;
    int unsigned random_end;

    // Directed: strays ahead of any message start, at both digit extremes.
    nibble_feed.push_back('{4'h0, 1'b0});
    nibble_feed.push_back('{4'hF, 1'b0});
    nibble_feed.push_back('{4'h5, 1'b0});
    // No field present: the message ends on the last bitmap nibble.
    build_message('0, 12, -1);
    // Only the secondary bitmap bit and empty fixed fields: skipped, same ending.
    fmap = '0;
    fmap[0] = 1'b1;
    fmap[9:4] = '1;
    build_message(fmap, 12, -1);
    add_strays(2);
    // Over-limit odd left BCD, zero declared length, a prefix halted by a
    // non-decimal digit, padded fixed left BCD, fixed ASCII and the last field.
    fmap = '0;
    fmap[1] = 1'b1;
    fmap[21] = 1'b1;
    fmap[34] = 1'b1;
    fmap[35] = 1'b1;
    fmap[51] = 1'b1;
    fmap[63] = 1'b1;
    prefix_script = '{4'd2, 4'd5, 4'd0, 4'd0, 4'd0, 4'd1, 4'hA, 4'd3};
    build_message(fmap, 12, -1);
    // Restart in the middle of a message.
    build_message(fmap, 12, 30);
    // Every field present, with short lengths.
    build_message('1, 3, -1);
    add_strays(1);

    // Random: mostly well-formed messages with random content, some cut short,
    // some followed by strays, and bursts of raw noise with random starts.
    random_end = nibble_feed.size() + RandomNibbles;
    while (nibble_feed.size() < random_end) begin
      if ($urandom_range(0, 6) != 0) begin
        build_message(random_map(), 12,
                      ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 60)) : -1);
        if ($urandom_range(0, 4) == 0) add_strays($urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          nibble_feed.push_back('{4'($urandom_range(0, 15)), ($urandom_range(0, 3) == 0)});
        end
      end
    end

    // Long lengths: an ASCII field one over its limit and an over-limit odd left BCD.
    fmap = '0;
    fmap[54] = 1'b1;
    fmap[59] = 1'b1;
    prefix_script = '{4'd0, 4'd2, 4'd5, 4'd6, 4'd0, 4'd0, 4'd1, 4'd9};
    build_message(fmap, 12, -1);
    add_strays(3);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all nibbles sent, all tags returned, then let the pipeline settle.
    while (nibble_feed.size() != 0 || in_bus.valid) @(negedge clk_i);
    while (tagged_nibbles.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
